// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared codes, frame layout constants and control/status types for the
// stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ESCAPE   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_START       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESCAPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd4;

  // frame layout: version, destination, source, sequence, command, length
  localparam int POS_VERSION  = 0;
  localparam int POS_DEST     = 1;
  localparam int POS_SOURCE   = 2;
  localparam int POS_SEQUENCE = 3;
  localparam int POS_COMMAND  = 4;
  localparam int POS_LENGTH   = 5;
  localparam int HDR_LEN      = 6;
  localparam int FRAME_MIN    = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic step;
    logic load_stat;
    logic load_data;
    logic inc_k;
  } sfr_cmd_t;

  typedef struct packed {
    logic ev_fail;
    logic ev_ok;
    logic out_free;
    logic last_item;
  } sfr_sts_t;

endpackage

// File: sv/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer: takes raw words while idle, then hands a failure status or the
// payload of a checked frame to the output register.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sfr_sts_t sts,
  output sfr_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STAT = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          if (sts.ev_fail) begin
            state_nxt = S_STAT;
          end else if (sts.ev_ok) begin
            state_nxt = S_RD;
          end
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load_data = 1'b1;
          if (sts.last_item) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.inc_k = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef ASSERT_OFF
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_stat || cmd.load_data) |-> sts.out_free)
    else $error("output load while output register busy");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_data && sts.last_item) |=> (state_r == S_IDLE))
    else $error("payload drain did not end after last word");
`endif

endmodule

// File: sv/sfr_dp.sv
// ----------------------------------------------------------------------------
// sfr_dp
// Datapath: configuration registers, unstuffing, frame store, running
// CRC-16/Modbus, header capture, close checks and the output register.
// ----------------------------------------------------------------------------
module sfr_dp
  import sfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32,
  parameter int STORE_DEPTH = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [7:0]           out_destination,
  output logic [7:0]           out_source,
  output logic [7:0]           out_sequence_res,
  output logic [7:0]           out_command,
  output logic [5:0]           out_payload_length,
  output logic [4:0]           out_byte_index,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last,
  input  sfr_cmd_t             cmd,
  output sfr_sts_t             sts
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int KW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  logic [7:0] start_r, escape_r, esc_start_r, esc_esc_r, version_exp_r;

  logic          in_frame_r, in_frame_nxt;
  logic          esc_r, esc_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_r;
  logic [AW-1:0] rd_addr;

  logic [7:0]  hdr_ver_r, hdr_dest_r, hdr_src_r, hdr_seq_r, hdr_cmd_r, plen_r;
  logic [15:0] crc_r;
  logic [7:0]  b1_r, b2_r;
  logic [STATUS_W-1:0] code_r;
  logic [KW-1:0] k_r;

  logic                is_start;
  logic                want_store;
  logic                do_store;
  logic [7:0]          data;
  logic                ev_fail, ev_ok;
  logic [STATUS_W-1:0] fail_code;
  logic [STATUS_W-1:0] chk_code;
  logic                out_free;
  logic                k_last;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [7:0]          out_dest_r, out_src_r, out_seq_r, out_cmd_r, out_pbyte_r;
  logic [5:0]          out_plen_r;
  logic [4:0]          out_idx_r;
  logic                out_last_r;

  // close checks, in priority order
  always_comb begin
    if (10'(fill_r) < 10'(FRAME_MIN)) begin
      chk_code = ST_SHORT;
    end else if (hdr_ver_r != version_exp_r) begin
      chk_code = ST_VERSION;
    end else if ((plen_r > 8'(PAYLOAD_MAX)) ||
                 (10'(fill_r) != 10'(plen_r) + 10'(FRAME_MIN)) ||
                 (10'(plen_r) + 10'(HDR_LEN + 1) >= 10'(STORE_DEPTH))) begin
      chk_code = ST_LENGTH;
    end else if ({b1_r, b2_r} != crc_r) begin
      chk_code = ST_CRC;
    end else begin
      chk_code = ST_OK;
    end
  end

  always_comb begin
    is_start     = (in_rx_byte == start_r);
    data         = in_rx_byte;
    want_store   = 1'b0;
    do_store     = 1'b0;
    ev_fail      = 1'b0;
    ev_ok        = 1'b0;
    fail_code    = ST_OK;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    fill_nxt     = fill_r;
    if (is_start) begin
      in_frame_nxt = 1'b1;
      esc_nxt      = 1'b0;
      fill_nxt     = '0;
      if (in_frame_r && (fill_r != '0)) begin
        if (chk_code == ST_OK) begin
          ev_ok = 1'b1;
        end else begin
          ev_fail   = 1'b1;
          fail_code = chk_code;
        end
      end
    end else if (in_frame_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (in_rx_byte == esc_start_r) begin
          data       = start_r;
          want_store = 1'b1;
        end else if (in_rx_byte == esc_esc_r) begin
          data       = escape_r;
          want_store = 1'b1;
        end else begin
          in_frame_nxt = 1'b0;
          fill_nxt     = '0;
          ev_fail      = 1'b1;
          fail_code    = ST_ESCAPE;
        end
      end else if (in_rx_byte == escape_r) begin
        esc_nxt = 1'b1;
      end else begin
        want_store = 1'b1;
      end
      if (want_store) begin
        if (fill_r == FW'(STORE_DEPTH)) begin
          in_frame_nxt = 1'b0;
          fill_nxt     = '0;
          ev_fail      = 1'b1;
          fail_code    = ST_OVERFLOW;
        end else begin
          do_store = 1'b1;
          fill_nxt = fill_r + FW'(1);
        end
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = (plen_r == 8'd0) || ((8'(k_r) + 8'd1) == plen_r);
  assign rd_addr  = AW'(k_r) + AW'(HDR_LEN);

  always_comb begin
    sts.ev_fail   = ev_fail;
    sts.ev_ok     = ev_ok;
    sts.out_free  = out_free;
    sts.last_item = k_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 8'h7E;
      escape_r      <= 8'h7D;
      esc_start_r   <= 8'h5E;
      esc_esc_r     <= 8'h5D;
      version_exp_r <= 8'h01;
      in_frame_r    <= 1'b0;
      esc_r         <= 1'b0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START:      start_r       <= cfg_wdata;
          CFG_ESCAPE:     escape_r      <= cfg_wdata;
          CFG_ESC_START:  esc_start_r   <= cfg_wdata;
          CFG_ESC_ESCAPE: esc_esc_r     <= cfg_wdata;
          CFG_VERSION:    version_exp_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.step) begin
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        fill_r     <= fill_nxt;
      end
      if (cmd.load_stat || cmd.load_data) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && do_store) begin
      mem[fill_r[AW-1:0]] <= data;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      k_r <= '0;
      if (ev_fail) begin
        code_r <= fail_code;
      end
      if (is_start) begin
        crc_r <= CRC_INIT;
      end else if (do_store) begin
        b1_r <= data;
        b2_r <= b1_r;
        if (10'(fill_r) >= 10'd2) begin
          crc_r <= crc_byte(crc_r, b2_r);
        end
        if (fill_r == FW'(POS_VERSION))  hdr_ver_r  <= data;
        if (fill_r == FW'(POS_DEST))     hdr_dest_r <= data;
        if (fill_r == FW'(POS_SOURCE))   hdr_src_r  <= data;
        if (fill_r == FW'(POS_SEQUENCE)) hdr_seq_r  <= data;
        if (fill_r == FW'(POS_COMMAND))  hdr_cmd_r  <= data;
        if (fill_r == FW'(POS_LENGTH))   plen_r     <= data;
      end
    end else if (cmd.inc_k) begin
      k_r <= k_r + KW'(1);
    end
    if (cmd.load_stat) begin
      out_status_r <= code_r;
      out_dest_r   <= 8'd0;
      out_src_r    <= 8'd0;
      out_seq_r    <= 8'd0;
      out_cmd_r    <= 8'd0;
      out_plen_r   <= 6'd0;
      out_idx_r    <= 5'd0;
      out_pbyte_r  <= 8'd0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_data) begin
      out_status_r <= ST_OK;
      out_dest_r   <= hdr_dest_r;
      out_src_r    <= hdr_src_r;
      out_seq_r    <= hdr_seq_r;
      out_cmd_r    <= hdr_cmd_r;
      out_plen_r   <= plen_r[5:0];
      out_idx_r    <= 5'(k_r);
      out_pbyte_r  <= (plen_r == 8'd0) ? 8'd0 : rd_r;
      out_last_r   <= k_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_destination    = out_dest_r;
  assign out_source         = out_src_r;
  assign out_sequence_res   = out_seq_r;
  assign out_command        = out_cmd_r;
  assign out_payload_length = out_plen_r;
  assign out_byte_index     = out_idx_r;
  assign out_payload_byte   = out_pbyte_r;
  assign out_last           = out_last_r;

`ifndef ASSERT_OFF
  a_idle_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (fill_r == '0))
    else $error("store holds words outside a frame");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> in_frame_r)
    else $error("escape pending outside a frame");
`endif

endmodule

// File: sv/stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed frame receiver with header, length and CRC-16/Modbus checks.
// ----------------------------------------------------------------------------
// Raw words are taken one per cycle while no result is being produced; a word
// that ends in an escape or overflow failure, or closes a bad frame, then has
// its status result placed once the output register is free. Closing a good
// frame drains the stored payload through the single read port of the frame
// store, each payload word read and then loaded into the output register, one
// result for an empty payload, waiting while the output is stalled. The
// input is stalled during that drain. The output register lets a finished
// result wait while new raw words are taken. No clearing pass after reset.
module stuffed_frame_receiver
  import sfr_pkg::*;
#(
  parameter int PAYLOAD_MAX = 32,
  parameter int STORE_DEPTH = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [7:0]           out_destination,
  output logic [7:0]           out_source,
  output logic [7:0]           out_sequence_res,
  output logic [7:0]           out_command,
  output logic [5:0]           out_payload_length,
  output logic [4:0]           out_byte_index,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_rx_byte         (in_rx_byte),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_destination    (out_destination),
    .out_source         (out_source),
    .out_sequence_res   (out_sequence_res),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_byte_index     (out_byte_index),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
